// ----- design/tmavg_pkg.sv -----
// Shared types and constants for the three-axis moving average block.
`timescale 1ns / 1ps
`default_nettype none

package tmavg_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WINDOW_DEF = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_x;
    logic signed [SAMPLE_W-1:0] mean_y;
    logic signed [SAMPLE_W-1:0] mean_z;
  } mean_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE
  } state_t;

endpackage

`default_nettype wire

// ----- design/tmavg_div.sv -----
// Restoring divider, one quotient bit per cycle, signed sum over unsigned count.
`timescale 1ns / 1ps
`default_nettype none

module tmavg_div import tmavg_pkg::*; #(
  parameter int SUM_W = 20,
  parameter int DIV_W = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SUM_W-1:0]    dividend,
  input  logic        [DIV_W-1:0]    divisor,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [SUM_W-1:0] dq;     // dividend shifts out the top, quotient in at the bottom
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;

  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;
  logic              ge;
  logic [SUM_W-1:0]  mag_in;
  logic [SAMPLE_W-1:0] mag;

  assign shifted = {rem, dq[SUM_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = (shifted >= {1'b0, dvs});
  assign mag_in  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(SUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      dq  <= mag_in;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      dq  <= {dq[SUM_W-2:0], ge};
    end
  end

  // |mean| <= 32768, so the low bits carry the whole magnitude
  assign mag      = dq[SAMPLE_W-1:0];
  assign quotient = signed'(neg ? (~mag + 1'b1) : mag);

endmodule

`default_nettype wire

// ----- design/three_axis_moving_average.sv -----
// Top level: three-axis moving average over a ring of the last WINDOW samples.
//
// Usage notes
// - Input channel (sample_valid / sample_stall / sample): one item carries one
//   x/y/z sample, accepted when sample_valid is high and sample_stall is low.
// - Output channel (mean_valid / mean_stall / mean): one item per input item,
//   each axis' running sum divided by the sample count (WINDOW once the ring
//   has wrapped), truncated toward zero.
// - From accept to mean_valid an item passes the ring read, the update state
//   that writes back and starts the dividers, the bit-serial dividers (one
//   quotient bit per cycle per axis, SUM_W = 16 + clog2(WINDOW)), then the output register.
// - One item at a time: sample_stall stays high until the item's mean is loaded.
//   The steps are reading the ring memory, updating sums and writing back,
//   dividing, and loading the output register.
// - The history ring is one synchronous memory of WINDOW x 48 bits. Entries
//   not yet written since reset read as zero through the window_full flag,
//   so no clearing pass is needed.
// - Reset (rst, synchronous) clears state, sums, write slot, fill flag and mean_valid; mean data is not reset.
// - A stalled result waits in the output register; the next item is still
//   accepted and worked on, and only its output load waits for the register.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_moving_average import tmavg_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  sample_t sample,
  output logic    mean_valid,
  input  logic    mean_stall,
  output mean_t   mean
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int DIV_W  = $clog2(WINDOW + 1);
  localparam int EXT_W  = SUM_W - SAMPLE_W;

  state_t state, state_next;

  // ring memory and its registered read port
  sample_t hist_mem [WINDOW];
  sample_t hist_rd;
  sample_t sample_q;

  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic signed [SUM_W-1:0] sum_x_next, sum_y_next, sum_z_next;
  logic [SLOT_W-1:0]       write_slot, slot_next;
  logic                    window_full, full_next;
  logic                    wrap;
  logic [DIV_W-1:0]        divisor;

  logic accept, mem_we, div_start, mean_load;
  logic [2:0] div_done;
  logic signed [SAMPLE_W-1:0] q_x, q_y, q_z;
  sample_t old;

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    mean_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        mem_we     = 1'b1;
        div_start  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if ((&div_done) && (!mean_valid || !mean_stall)) begin
          mean_load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // History ring: read at accept, write back during the update cycle.
  // The two accesses never overlap, since one item is in flight at a time.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[write_slot] <= sample_q;
    if (accept) hist_rd <= hist_mem[write_slot];
  end

  always_ff @(posedge clk) begin
    if (accept) sample_q <= sample;
  end

  // Before the first wrap the slot being replaced was never written: zero.
  assign old = window_full ? hist_rd : '0;

  assign sum_x_next = sum_x - {{EXT_W{old.accel_x[SAMPLE_W-1]}}, old.accel_x}
                            + {{EXT_W{sample_q.accel_x[SAMPLE_W-1]}}, sample_q.accel_x};
  assign sum_y_next = sum_y - {{EXT_W{old.accel_y[SAMPLE_W-1]}}, old.accel_y}
                            + {{EXT_W{sample_q.accel_y[SAMPLE_W-1]}}, sample_q.accel_y};
  assign sum_z_next = sum_z - {{EXT_W{old.accel_z[SAMPLE_W-1]}}, old.accel_z}
                            + {{EXT_W{sample_q.accel_z[SAMPLE_W-1]}}, sample_q.accel_z};

  assign wrap      = (write_slot == SLOT_W'(WINDOW - 1));
  assign slot_next = wrap ? '0 : write_slot + 1'b1;
  assign full_next = window_full || wrap;
  // count so far is the advanced slot; it is never zero before the wrap
  assign divisor   = full_next ? DIV_W'(WINDOW) : DIV_W'(slot_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x       <= '0;
      sum_y       <= '0;
      sum_z       <= '0;
      write_slot  <= '0;
      window_full <= 1'b0;
    end else if (mem_we) begin
      sum_x       <= sum_x_next;
      sum_y       <= sum_y_next;
      sum_z       <= sum_z_next;
      write_slot  <= slot_next;
      window_full <= full_next;
    end
  end

  // ---------------------------------------------------------------------
  // One serial divider per axis, all started together
  // ---------------------------------------------------------------------
  tmavg_div #(.SUM_W(SUM_W), .DIV_W(DIV_W)) u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_x_next),
    .divisor(divisor), .done(div_done[0]), .quotient(q_x)
  );

  tmavg_div #(.SUM_W(SUM_W), .DIV_W(DIV_W)) u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_y_next),
    .divisor(divisor), .done(div_done[1]), .quotient(q_y)
  );

  tmavg_div #(.SUM_W(SUM_W), .DIV_W(DIV_W)) u_div_z (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_z_next),
    .divisor(divisor), .done(div_done[2]), .quotient(q_z)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_valid <= 1'b0;
    end else if (mean_load) begin
      mean_valid <= 1'b1;
    end else if (!mean_stall) begin
      mean_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mean_load) begin
      mean.mean_x <= q_x;
      mean.mean_y <= q_y;
      mean.mean_z <= q_z;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= SLOT_W'(WINDOW - 1))
    else $error("write slot beyond ring depth");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    window_full |=> window_full)
    else $error("window_full cleared without reset");

  a_accept_update: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_UPDATE))
    else $error("accepted item did not move to update");

  a_load_after_div: assert property (@(posedge clk) disable iff (rst)
    $rose(mean_valid) |-> ($past(state) == ST_DIVIDE) && $past(&div_done))
    else $error("result presented without a finished division");

  a_dividers_lockstep: assert property (@(posedge clk) disable iff (rst)
    (div_done[0] == div_done[1]) && (div_done[1] == div_done[2]))
    else $error("axis dividers out of step");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for the three-axis moving average: queued samples, a shadow ring, per-field mean checks.
`timescale 1ns / 1ps

module testbench;
  import tmavg_pkg::*;

  localparam int          WIN          = WINDOW_DEF;
  localparam int          MAX_GAP      = 12;
  localparam int          TOTAL_ITEMS  = 1050;
  localparam int          DRAIN_CYCLES = 60;
  localparam longint      CYCLE_LIMIT  = 400000;

  typedef struct {
    sample_t     s;
    int unsigned gap;
  } pending_sample_t;

  logic    clk;
  logic    rst          = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_stall;
  sample_t sample       = '0;
  logic    mean_valid;
  logic    mean_stall   = 1'b0;
  mean_t   mean;

  pending_sample_t pending_samples[$];
  mean_t           expected_means[$];

  // Shadow copy of the filter state
  logic signed [SAMPLE_W-1:0] ring_x[WIN];
  logic signed [SAMPLE_W-1:0] ring_y[WIN];
  logic signed [SAMPLE_W-1:0] ring_z[WIN];
  longint      sum_x, sum_y, sum_z;
  int unsigned fill_slot;
  bit          ring_full;

  int unsigned     queued_count   = 0;
  int unsigned     accepted_count = 0;
  int unsigned     checked_count  = 0;
  int unsigned     wrap_count     = 0;
  int unsigned     error_count    = 0;
  longint unsigned cycle_count    = 0;
  bit              in_burst       = 1'b0;
  bit              out_burst      = 1'b0;

  // Driver state
  int unsigned wait_left  = 0;
  sample_t     staged     = '0;
  // Receiver state
  int unsigned stall_left = 0;

  three_axis_moving_average #(
    .WINDOW(WIN)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .mean_valid  (mean_valid),
    .mean_stall  (mean_stall),
    .mean        (mean)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_ring();
    for (int i = 0; i < WIN; i++) begin
      ring_x[i] = '0;
      ring_y[i] = '0;
      ring_z[i] = '0;
    end
    sum_x     = 0;
    sum_y     = 0;
    sum_z     = 0;
    fill_slot = 0;
    ring_full = 1'b0;
  endtask

  // Drop the oldest sample, store the new one, advance the slot, divide.
  task automatic predict_mean(input sample_t s);
    mean_t  m;
    longint divisor;
    sum_x = sum_x - ring_x[fill_slot] + s.accel_x;
    sum_y = sum_y - ring_y[fill_slot] + s.accel_y;
    sum_z = sum_z - ring_z[fill_slot] + s.accel_z;
    ring_x[fill_slot] = s.accel_x;
    ring_y[fill_slot] = s.accel_y;
    ring_z[fill_slot] = s.accel_z;
    if (fill_slot == WIN - 1) begin
      fill_slot = 0;
      ring_full = 1'b1;
      wrap_count++;
    end else begin
      fill_slot++;
    end
    divisor  = ring_full ? longint'(WIN) : longint'(fill_slot);
    // signed longint division truncates toward zero
    m.mean_x = SAMPLE_W'(sum_x / divisor);
    m.mean_y = SAMPLE_W'(sum_y / divisor);
    m.mean_z = SAMPLE_W'(sum_z / divisor);
    expected_means.push_back(m);
  endtask

  task automatic queue_sample(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
    pending_sample_t p;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    p.s.accel_x = x;
    p.s.accel_y = y;
    p.s.accel_z = z;
    p.gap       = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    pending_samples.push_back(p);
    queued_count++;
  endtask

  // Driver: gap before each item, payload held while stalled
  always @(posedge clk) begin
    pending_sample_t nxt;
    if (rst) begin
      sample_valid <= 1'b0;
      wait_left    <= 0;
    end else if (!sample_valid || !sample_stall) begin
      if (wait_left > 1) begin
        sample_valid <= 1'b0;
        wait_left    <= wait_left - 1;
      end else if (wait_left == 1) begin
        sample_valid <= 1'b1;
        sample       <= staged;
        wait_left    <= 0;
      end else if (pending_samples.size() > 0) begin
        nxt = pending_samples.pop_front();
        if (nxt.gap == 0) begin
          sample_valid <= 1'b1;
          sample       <= nxt.s;
        end else begin
          sample_valid <= 1'b0;
          staged       <= nxt.s;
          wait_left    <= nxt.gap;
        end
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Shadow filter follows every accepted sample
  always @(posedge clk) begin
    if (rst) begin
      clear_ring();
    end else if (sample_valid && !sample_stall) begin
      predict_mean(sample);
      accepted_count++;
    end
  end

  // Receiver: stall count runs only while a mean is offered
  always @(posedge clk) begin
    mean_t       want;
    int unsigned n;
    if (rst) begin
      mean_stall <= 1'b0;
      stall_left <= 0;
    end else if (mean_valid && !mean_stall) begin
      if (expected_means.size() == 0) begin
        $error("mean item with no sample waiting for it: %p", mean);
        error_count++;
      end else begin
        want = expected_means.pop_front();
        if (mean.mean_x !== want.mean_x) begin
          $error("mean_x expected %0d got %0d", want.mean_x, mean.mean_x);
          error_count++;
        end
        if (mean.mean_y !== want.mean_y) begin
          $error("mean_y expected %0d got %0d", want.mean_y, mean.mean_y);
          error_count++;
        end
        if (mean.mean_z !== want.mean_z) begin
          $error("mean_z expected %0d got %0d", want.mean_z, mean.mean_z);
          error_count++;
        end
        checked_count++;
      end
      if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
      n = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      stall_left <= n;
      mean_stall <= (n != 0);
    end else if (mean_valid && stall_left > 0) begin
      stall_left <= stall_left - 1;
      mean_stall <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d means still owed", cycle_count,
               expected_means.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] vx, vy, vz;
    int unsigned run_len;

    // Directed: first sample alone, then partial windows with extremes and
    // negative sums that truncate toward zero, the wrap, and past it.
    queue_sample(16'h7FFF, 16'h8000, 16'h0000);
    queue_sample(16'h8000, 16'h7FFF, 16'hFFFF);
    queue_sample(16'hFFFF, 16'h0001, 16'h8000);
    for (int i = 0; i < 13; i++) queue_sample(16'h7FFF, 16'h8000, 16'hFFFF);
    queue_sample(16'h5555, 16'hAAAA, 16'h0001);
    queue_sample(16'hAAAA, 16'h5555, 16'h8000);
    queue_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_sample(16'h8000, 16'h8000, 16'h8000);

    // Random: mostly full-range samples, some near-zero values for rounding,
    // and runs of full-scale samples long enough to fill the whole window.
    while (queued_count < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          vx      = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          vy      = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          vz      = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          run_len = WIN + $urandom_range(0, 4);
          repeat (run_len) queue_sample(vx, vy, vz);
        end
        1: begin
          vx = 16'($urandom_range(0, 40)) - 16'd20;
          vy = 16'($urandom_range(0, 40)) - 16'd20;
          vz = 16'($urandom_range(0, 40)) - 16'd20;
          queue_sample(vx, vy, vz);
        end
        default: queue_sample(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < queued_count || expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples, %0d means compared, window of %0d wrapped %0d times",
             accepted_count, checked_count, WIN, wrap_count);
    $display("with random source gaps and sink stalls over %0d cycles; %0d mismatches.",
             cycle_count, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/tmavg_pkg.sv
design/tmavg_div.sv
design/three_axis_moving_average.sv
sim/testbench.sv
